@@ rtl/core/rti_pkg.sv @@
// Shared constants and types for the ray/triangle intersection pipeline.
package rti_pkg;

    localparam int COORD_WIDTH_DEF = 16;
    localparam int DIST_WIDTH_DEF  = 32;
    localparam int DIR_WIDTH       = 16;
    localparam int REG_WIDTH       = 48;
    localparam int COORD_FRAC      = 8;
    localparam int DIR_FRAC        = 14;
    localparam int DIST_FRAC       = 16;
    localparam int T_SHIFT         = DIST_FRAC + DIR_FRAC - COORD_FRAC;
    localparam int CFG_IDX_WIDTH   = 2;

    typedef enum logic [CFG_IDX_WIDTH-1:0] {
        CFG_VERTEX_A = 2'd0,
        CFG_VERTEX_B = 2'd1,
        CFG_VERTEX_C = 2'd2
    } cfg_index_t;

    typedef enum logic [2:0] {
        OUT_HIT        = 3'd0,
        OUT_PARALLEL   = 3'd1,
        OUT_BEHIND     = 3'd2,
        OUT_NOT_CLOSER = 3'd3,
        OUT_OUTSIDE    = 3'd4
    } outcome_t;

endpackage

@@ rtl/core/ray_triangle_intersect_top.sv @@
// Pipelined ray/triangle intersection test with configurable triangle vertices.
// Pipeline: six arithmetic stages, then one quotient bit per stage for t, then the
// registered final classification that drives the result strobe (done).
// Throughput: one transaction per cycle; busy is always low, the receiver cannot stall.
// Reset (rst_n low, async) clears all valid bits and the vertex registers to zero.
module ray_triangle_intersect_top
    import rti_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF,
    parameter int DIST_WIDTH  = DIST_WIDTH_DEF
)(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [CFG_IDX_WIDTH-1:0]      cfg_index,
    input  logic [REG_WIDTH-1:0]          cfg_data,
    input  logic                          start,
    output logic                          busy,
    input  logic signed [COORD_WIDTH-1:0] origin_x,
    input  logic signed [COORD_WIDTH-1:0] origin_y,
    input  logic signed [COORD_WIDTH-1:0] origin_z,
    input  logic signed [DIR_WIDTH-1:0]   dir_x,
    input  logic signed [DIR_WIDTH-1:0]   dir_y,
    input  logic signed [DIR_WIDTH-1:0]   dir_z,
    input  logic [DIST_WIDTH-1:0]         closest_so_far,
    output logic                          done,
    output logic                          hit,
    output logic [DIST_WIDTH-1:0]         hit_distance,
    output logic [2:0]                    outcome
);

    localparam int EW   = COORD_WIDTH + 1;
    localparam int OPW  = (EW > DIR_WIDTH) ? EW : DIR_WIDTH;
    localparam int MW   = 2 * OPW;
    localparam int CWX  = MW + 1;
    localparam int SW   = OPW + CWX + 2;
    localparam int NUMW = SW + T_SHIFT;
    localparam int PKW  = (3 * COORD_WIDTH > REG_WIDTH) ? 3 * COORD_WIDTH : REG_WIDTH;
    localparam logic [DIST_WIDTH-1:0] DMAX = {DIST_WIDTH{1'b1}};

    // configuration
    logic [REG_WIDTH-1:0] vertex_a_reg, vertex_b_reg, vertex_c_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vertex_a_reg <= '0;
            vertex_b_reg <= '0;
            vertex_c_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_VERTEX_A: vertex_a_reg <= cfg_data;
                CFG_VERTEX_B: vertex_b_reg <= cfg_data;
                CFG_VERTEX_C: vertex_c_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    logic [PKW-1:0] va_w, vb_w, vc_w;
    assign va_w = PKW'(vertex_a_reg);
    assign vb_w = PKW'(vertex_b_reg);
    assign vc_w = PKW'(vertex_c_reg);

    logic signed [COORD_WIDTH-1:0] va [3];
    logic signed [COORD_WIDTH-1:0] vb [3];
    logic signed [COORD_WIDTH-1:0] vc [3];
    logic signed [COORD_WIDTH-1:0] org [3];
    logic signed [DIR_WIDTH-1:0]   dirv [3];

    assign org[0]  = origin_x;
    assign org[1]  = origin_y;
    assign org[2]  = origin_z;
    assign dirv[0] = dir_x;
    assign dirv[1] = dir_y;
    assign dirv[2] = dir_z;

    assign busy = 1'b0;
    logic accept;
    assign accept = start && !busy;

    // stage 1: edges and origin offset
    logic                  s1_valid_reg;
    logic signed [OPW-1:0] s1_e1_reg [3];
    logic signed [OPW-1:0] s1_e2_reg [3];
    logic signed [OPW-1:0] s1_tv_reg [3];
    logic signed [OPW-1:0] s1_d_reg  [3];
    logic [DIST_WIDTH-1:0] s1_cl_reg;

    // stage 2: cross-product partial products
    logic                  s2_valid_reg;
    logic signed [MW-1:0]  s2_na_reg [3], s2_nb_reg [3];
    logic signed [MW-1:0]  s2_pa_reg [3], s2_pb_reg [3];
    logic signed [MW-1:0]  s2_qa_reg [3], s2_qb_reg [3];
    logic signed [OPW-1:0] s2_tv_reg [3];
    logic signed [OPW-1:0] s2_d_reg  [3];
    logic [DIST_WIDTH-1:0] s2_cl_reg;

    // stage 3: n, p, q
    logic                  s3_valid_reg;
    logic signed [CWX-1:0] s3_n_reg [3], s3_p_reg [3], s3_q_reg [3];
    logic signed [OPW-1:0] s3_tv_reg [3];
    logic signed [OPW-1:0] s3_d_reg  [3];
    logic [DIST_WIDTH-1:0] s3_cl_reg;

    // stage 4: dot-product terms
    logic                  s4_valid_reg;
    logic signed [SW-1:0]  s4_den_reg [3], s4_num_reg [3], s4_u_reg [3], s4_v_reg [3];
    logic [DIST_WIDTH-1:0] s4_cl_reg;

    // stage 5: sums
    logic                  s5_valid_reg;
    logic signed [SW-1:0]  s5_den_reg, s5_num_reg, s5_u_reg, s5_v_reg;
    logic [DIST_WIDTH-1:0] s5_cl_reg;

    genvar k;
    generate
        for (k = 0; k < 3; k++)
        begin : g_vec
            localparam int J = (k + 1) % 3;
            localparam int L = (k + 2) % 3;
            assign va[k] = signed'(va_w[k*COORD_WIDTH +: COORD_WIDTH]);
            assign vb[k] = signed'(vb_w[k*COORD_WIDTH +: COORD_WIDTH]);
            assign vc[k] = signed'(vc_w[k*COORD_WIDTH +: COORD_WIDTH]);

            always_ff @(posedge clk)
            begin
                s1_e1_reg[k] <= OPW'(vb[k]) - OPW'(va[k]);
                s1_e2_reg[k] <= OPW'(vc[k]) - OPW'(va[k]);
                s1_tv_reg[k] <= OPW'(org[k]) - OPW'(va[k]);
                s1_d_reg[k]  <= OPW'(dirv[k]);

                // n = e2 x e1, p = d x e2, q = tv x e1
                s2_na_reg[k] <= MW'(s1_e2_reg[J]) * MW'(s1_e1_reg[L]);
                s2_nb_reg[k] <= MW'(s1_e2_reg[L]) * MW'(s1_e1_reg[J]);
                s2_pa_reg[k] <= MW'(s1_d_reg[J])  * MW'(s1_e2_reg[L]);
                s2_pb_reg[k] <= MW'(s1_d_reg[L])  * MW'(s1_e2_reg[J]);
                s2_qa_reg[k] <= MW'(s1_tv_reg[J]) * MW'(s1_e1_reg[L]);
                s2_qb_reg[k] <= MW'(s1_tv_reg[L]) * MW'(s1_e1_reg[J]);
                s2_tv_reg[k] <= s1_tv_reg[k];
                s2_d_reg[k]  <= s1_d_reg[k];

                s3_n_reg[k]  <= CWX'(s2_na_reg[k]) - CWX'(s2_nb_reg[k]);
                s3_p_reg[k]  <= CWX'(s2_pa_reg[k]) - CWX'(s2_pb_reg[k]);
                s3_q_reg[k]  <= CWX'(s2_qa_reg[k]) - CWX'(s2_qb_reg[k]);
                s3_tv_reg[k] <= s2_tv_reg[k];
                s3_d_reg[k]  <= s2_d_reg[k];

                s4_den_reg[k] <= SW'(s3_d_reg[k])  * SW'(s3_n_reg[k]);
                s4_num_reg[k] <= SW'(s3_tv_reg[k]) * SW'(s3_n_reg[k]);
                s4_u_reg[k]   <= SW'(s3_tv_reg[k]) * SW'(s3_p_reg[k]);
                s4_v_reg[k]   <= SW'(s3_d_reg[k])  * SW'(s3_q_reg[k]);
            end
        end
    endgenerate

    always_ff @(posedge clk)
    begin
        s1_cl_reg  <= closest_so_far;
        s2_cl_reg  <= s1_cl_reg;
        s3_cl_reg  <= s2_cl_reg;
        s4_cl_reg  <= s3_cl_reg;
        s5_cl_reg  <= s4_cl_reg;
        s5_den_reg <= s4_den_reg[0] + s4_den_reg[1] + s4_den_reg[2];
        s5_num_reg <= -(s4_num_reg[0] + s4_num_reg[1] + s4_num_reg[2]);
        s5_u_reg   <= s4_u_reg[0] + s4_u_reg[1] + s4_u_reg[2];
        s5_v_reg   <= s4_v_reg[0] + s4_v_reg[1] + s4_v_reg[2];
    end

    // stage 6: sign fold, early rejects, divider setup
    logic signed [SW-1:0] aden, anum, au, av;
    logic signed [SW:0]   uv_sum;
    logic                 flip;
    logic [NUMW-1:0]      dividend, div_hi;
    logic                 c_parallel, c_behind, c_outside, c_over;

    always_comb
    begin
        flip       = s5_den_reg < 0;
        aden       = flip ? -s5_den_reg : s5_den_reg;
        anum       = flip ? -s5_num_reg : s5_num_reg;
        au         = flip ? -s5_u_reg : s5_u_reg;
        av         = flip ? -s5_v_reg : s5_v_reg;
        uv_sum     = (SW+1)'(au) + (SW+1)'(av);
        c_parallel = s5_den_reg == 0;
        c_behind   = anum <= 0;
        c_outside  = (au < 0) || (av < 0) || (uv_sum > (SW+1)'(aden));
        dividend   = {unsigned'(anum), {T_SHIFT{1'b0}}};
        div_hi     = dividend >> DIST_WIDTH;
        // quotient would not fit in DIST_WIDTH bits
        c_over     = div_hi >= NUMW'(unsigned'(aden));
    end

    // divider stages: index 0 is the setup stage, one quotient bit per stage after it
    logic                  dv_valid_reg [DIST_WIDTH+1];
    logic [SW-1:0]         dv_rem_reg   [DIST_WIDTH+1];
    logic [SW-1:0]         dv_den_reg   [DIST_WIDTH+1];
    logic [DIST_WIDTH-1:0] dv_lo_reg    [DIST_WIDTH+1];
    logic [DIST_WIDTH-1:0] dv_q_reg     [DIST_WIDTH+1];
    logic [DIST_WIDTH-1:0] dv_cl_reg    [DIST_WIDTH+1];
    logic                  dv_early_reg [DIST_WIDTH+1];
    outcome_t              dv_code_reg  [DIST_WIDTH+1];
    logic                  dv_out_reg   [DIST_WIDTH+1];
    logic                  dv_over_reg  [DIST_WIDTH+1];

    logic [SW-1:0]         dv_rem_next [DIST_WIDTH];
    logic [DIST_WIDTH-1:0] dv_q_next   [DIST_WIDTH];

    always_comb
    begin
        for (int i = 0; i < DIST_WIDTH; i++)
        begin
            logic [SW:0] trial;
            trial = {dv_rem_reg[i], dv_lo_reg[i][DIST_WIDTH-1]};
            if (trial >= (SW+1)'(dv_den_reg[i]))
            begin
                dv_rem_next[i] = SW'(trial - (SW+1)'(dv_den_reg[i]));
                dv_q_next[i]   = {dv_q_reg[i][DIST_WIDTH-2:0], 1'b1};
            end
            else
            begin
                dv_rem_next[i] = trial[SW-1:0];
                dv_q_next[i]   = {dv_q_reg[i][DIST_WIDTH-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk)
    begin
        dv_rem_reg[0]   <= div_hi[SW-1:0];
        dv_den_reg[0]   <= unsigned'(aden);
        dv_lo_reg[0]    <= dividend[DIST_WIDTH-1:0];
        dv_q_reg[0]     <= '0;
        dv_cl_reg[0]    <= s5_cl_reg;
        dv_early_reg[0] <= c_parallel || c_behind;
        dv_code_reg[0]  <= c_parallel ? OUT_PARALLEL : OUT_BEHIND;
        dv_out_reg[0]   <= c_outside;
        dv_over_reg[0]  <= c_over;
        for (int i = 0; i < DIST_WIDTH; i++)
        begin
            dv_rem_reg[i+1]   <= dv_rem_next[i];
            dv_q_reg[i+1]     <= dv_q_next[i];
            dv_den_reg[i+1]   <= dv_den_reg[i];
            dv_lo_reg[i+1]    <= {dv_lo_reg[i][DIST_WIDTH-2:0], 1'b0};
            dv_cl_reg[i+1]    <= dv_cl_reg[i];
            dv_early_reg[i+1] <= dv_early_reg[i];
            dv_code_reg[i+1]  <= dv_code_reg[i];
            dv_out_reg[i+1]   <= dv_out_reg[i];
            dv_over_reg[i+1]  <= dv_over_reg[i];
        end
    end

    // final classification
    logic [DIST_WIDTH-1:0] t_sat;
    outcome_t              code_next;
    logic                  done_reg, hit_reg;
    logic [DIST_WIDTH-1:0] dist_reg;
    outcome_t              code_reg;

    always_comb
    begin
        t_sat = dv_over_reg[DIST_WIDTH] ? DMAX : dv_q_reg[DIST_WIDTH];
        if (dv_early_reg[DIST_WIDTH])
            code_next = dv_code_reg[DIST_WIDTH];
        else if (t_sat >= dv_cl_reg[DIST_WIDTH])
            code_next = OUT_NOT_CLOSER;
        else if (dv_out_reg[DIST_WIDTH])
            code_next = OUT_OUTSIDE;
        else
            code_next = OUT_HIT;
    end

    always_ff @(posedge clk)
    begin
        hit_reg  <= code_next == OUT_HIT;
        dist_reg <= (code_next == OUT_HIT) ? t_sat : '0;
        code_reg <= code_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
            s5_valid_reg <= 1'b0;
            for (int i = 0; i <= DIST_WIDTH; i++)
                dv_valid_reg[i] <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg    <= accept;
            s2_valid_reg    <= s1_valid_reg;
            s3_valid_reg    <= s2_valid_reg;
            s4_valid_reg    <= s3_valid_reg;
            s5_valid_reg    <= s4_valid_reg;
            dv_valid_reg[0] <= s5_valid_reg;
            for (int i = 0; i < DIST_WIDTH; i++)
                dv_valid_reg[i+1] <= dv_valid_reg[i];
            done_reg <= dv_valid_reg[DIST_WIDTH];
        end
    end

    assign done         = done_reg;
    assign hit          = hit_reg;
    assign hit_distance = dist_reg;
    assign outcome      = code_reg;

endmodule
